// ----- hdl/dstm_pkg.sv -----
// package with sizes, operation codes and status codes of the dual stack block
`timescale 1ns / 1ps

package dstm_pkg;

    // stack geometry
    localparam int STACK_DEPTH = 16;
    localparam int WORD_BITS   = 32;

    // derived sizes
    localparam int PTR_BITS  = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int CNT_BITS  = $clog2(STACK_DEPTH + 1);
    localparam int ADDR_BITS = PTR_BITS + 1;
    localparam int MEM_DEPTH = 2 * (1 << PTR_BITS);

    // fixed field widths of the stream beats
    localparam int VAL_BITS      = 32;
    localparam int DEPTH_BITS    = 5;
    localparam int OP_BITS       = 3;
    localparam int STATUS_BITS   = 2;
    localparam int IN_USER_BITS  = OP_BITS + 1;
    localparam int IN_DATA_BITS  = VAL_BITS;
    localparam int OUT_USER_BITS = STATUS_BITS;
    localparam int OUT_RAW_BITS  = 3 * VAL_BITS + 3 * DEPTH_BITS;
    localparam int OUT_DATA_BITS = ((OUT_RAW_BITS + 7) / 8) * 8;

    typedef logic signed [WORD_BITS-1:0] word_t;
    typedef logic [CNT_BITS-1:0]         cnt_t;

    // operation codes
    localparam logic [OP_BITS-1:0] OP_PUSH  = 3'd0;
    localparam logic [OP_BITS-1:0] OP_POP   = 3'd1;
    localparam logic [OP_BITS-1:0] OP_XFER  = 3'd2;
    localparam logic [OP_BITS-1:0] OP_QUERY = 3'd3;
    localparam logic [OP_BITS-1:0] OP_CLEAR = 3'd4;

    // status codes
    localparam logic [STATUS_BITS-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_BITS-1:0] ST_OVERFLOW  = 2'd1;
    localparam logic [STATUS_BITS-1:0] ST_UNDERFLOW = 2'd2;
    localparam logic [STATUS_BITS-1:0] ST_EMPTY     = 2'd3;

endpackage

// ----- hdl/dual_stack_transfer_minmax.sv -----
// two bounded stacks with push, pop, transfer, min/max query and clear
//
//  channel  dir  beat fields (lowest bit first)
//  s_*      in   tuser: operation[2:0], stack_select[3]; tdata: value[31:0]
//  m_*      out  tuser: status[1:0]; tdata: popped_value, largest, smallest,
//                moved_count, first_depth, second_depth, one zero pad bit
//
//  push, clear and unused codes go straight to the result; pop first reads the top (not on underflow)
//  transfer moves one word a cycle until the source is empty or the destination is full
//  query reads the stack one entry a cycle; an empty stack goes straight to the result
//  reset empties both stacks at once; the memory itself is never cleared
//  a new beat is accepted while the previous result waits on m_tready
`timescale 1ns / 1ps

module dual_stack_transfer_minmax
    import dstm_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     s_tvalid,
    output logic                     s_tready,
    // value[31:0]
    input  logic [IN_DATA_BITS-1:0]  s_tdata,
    // operation[2:0], stack_select[3]
    input  logic [IN_USER_BITS-1:0]  s_tuser,
    output logic                     m_tvalid,
    input  logic                     m_tready,
    // popped_value[31:0], largest[63:32], smallest[95:64], moved_count[100:96],
    // first_depth[105:101], second_depth[110:106], zero pad above
    output logic [OUT_DATA_BITS-1:0] m_tdata,
    // status[1:0]
    output logic [OUT_USER_BITS-1:0] m_tuser
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_POP,
        S_XFER,
        S_SCAN,
        S_EMIT
    } state_t;

    // word to 32-bit output field, sign extended or truncated
    function automatic logic [VAL_BITS-1:0] to_field(input word_t w);
        logic signed [63:0] t;
        t = 64'(w);
        return t[VAL_BITS-1:0];
    endfunction

    // count to 5-bit depth field, modulo the field width
    function automatic logic [DEPTH_BITS-1:0] to_depth(input cnt_t c);
        logic [63:0] t;
        t = 64'(c);
        return t[DEPTH_BITS-1:0];
    endfunction

    // stack memory, first stack in the lower half
    word_t                  mem [MEM_DEPTH];
    word_t                  rd_data_reg;
    logic                   rd_en;
    logic [ADDR_BITS-1:0]   rd_addr;
    logic                   wr_en;
    logic [ADDR_BITS-1:0]   wr_addr;
    word_t                  wr_data;

    state_t                 state_reg, state_next;
    logic                   sel_reg, sel_next;
    cnt_t                   first_cnt_reg, first_cnt_next;
    cnt_t                   second_cnt_reg, second_cnt_next;
    cnt_t                   idx_reg, idx_next;
    cnt_t                   moved_reg, moved_next;
    logic [PTR_BITS-1:0]    wr_ptr_reg, wr_ptr_next;
    logic                   pend_reg, pend_next;
    logic                   first_reg, first_next;
    logic [STATUS_BITS-1:0] status_reg, status_next;
    logic [VAL_BITS-1:0]    popped_reg, popped_next;
    word_t                  large_reg, large_next;
    word_t                  small_reg, small_next;
    logic                   m_tvalid_reg, m_tvalid_next;
    logic [OUT_DATA_BITS-1:0] m_tdata_reg, m_tdata_next;
    logic [OUT_USER_BITS-1:0] m_tuser_reg, m_tuser_next;

    logic                   in_accept;
    logic [OP_BITS-1:0]     in_op;
    logic                   in_sel;
    logic signed [63:0]     in_wide;
    word_t                  in_word;
    logic                   cur_sel;
    cnt_t                   src_cnt, dst_cnt, src_cnt_next, dst_cnt_next;
    logic                   issue;
    logic                   out_free;

    assign s_tready  = (state_reg == S_IDLE);
    assign in_accept = s_tvalid && s_tready;
    assign in_op     = s_tuser[OP_BITS-1:0];
    assign in_sel    = s_tuser[OP_BITS];
    assign in_wide   = 64'(signed'(s_tdata[VAL_BITS-1:0]));
    assign in_word   = in_wide[WORD_BITS-1:0];
    assign out_free  = !m_tvalid_reg || m_tready;

    // source and destination counts of the selected stack
    assign cur_sel = (state_reg == S_IDLE) ? in_sel : sel_reg;
    assign src_cnt = cur_sel ? second_cnt_reg : first_cnt_reg;
    assign dst_cnt = cur_sel ? first_cnt_reg : second_cnt_reg;

    // sequencer next state
    always_comb
    begin
        state_next    = state_reg;
        sel_next      = sel_reg;
        idx_next      = idx_reg;
        moved_next    = moved_reg;
        wr_ptr_next   = wr_ptr_reg;
        pend_next     = pend_reg;
        first_next    = first_reg;
        status_next   = status_reg;
        popped_next   = popped_reg;
        large_next    = large_reg;
        small_next    = small_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_tdata_next  = m_tdata_reg;
        m_tuser_next  = m_tuser_reg;
        src_cnt_next  = src_cnt;
        dst_cnt_next  = dst_cnt;
        issue         = 1'b0;
        rd_en         = 1'b0;
        rd_addr       = '0;
        wr_en         = 1'b0;
        wr_addr       = '0;
        wr_data       = in_word;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_accept)
                begin
                    sel_next    = in_sel;
                    idx_next    = '0;
                    moved_next  = '0;
                    pend_next   = 1'b0;
                    first_next  = 1'b1;
                    status_next = ST_OK;
                    popped_next = '0;
                    large_next  = '0;
                    small_next  = '0;
                    state_next  = S_EMIT;
                    unique case (in_op)
                        OP_PUSH:
                        begin
                            if (src_cnt >= CNT_BITS'(STACK_DEPTH))
                            begin
                                status_next = ST_OVERFLOW;
                            end
                            else
                            begin
                                wr_en        = 1'b1;
                                wr_addr      = {in_sel, src_cnt[PTR_BITS-1:0]};
                                src_cnt_next = src_cnt + 1'b1;
                            end
                        end
                        OP_POP:
                        begin
                            if (src_cnt == '0)
                            begin
                                status_next = ST_UNDERFLOW;
                            end
                            else
                            begin
                                src_cnt_next = src_cnt - 1'b1;
                                rd_en        = 1'b1;
                                rd_addr      = {in_sel, src_cnt_next[PTR_BITS-1:0]};
                                state_next   = S_POP;
                            end
                        end
                        OP_XFER:
                        begin
                            state_next = S_XFER;
                        end
                        OP_QUERY:
                        begin
                            if (src_cnt == '0)
                            begin
                                status_next = ST_EMPTY;
                            end
                            else
                            begin
                                state_next = S_SCAN;
                            end
                        end
                        OP_CLEAR:
                        begin
                            src_cnt_next = '0;
                        end
                        default:
                        begin
                            state_next = S_EMIT;
                        end
                    endcase
                end
            end

            S_POP:
            begin
                popped_next = to_field(rd_data_reg);
                state_next  = S_EMIT;
            end

            // one word a cycle: read the source top, write it in the following cycle
            S_XFER:
            begin
                if (pend_reg)
                begin
                    wr_en   = 1'b1;
                    wr_addr = {~sel_reg, wr_ptr_reg};
                    wr_data = rd_data_reg;
                end
                issue = (src_cnt != '0) && (dst_cnt < CNT_BITS'(STACK_DEPTH));
                if (issue)
                begin
                    src_cnt_next = src_cnt - 1'b1;
                    dst_cnt_next = dst_cnt + 1'b1;
                    rd_en        = 1'b1;
                    rd_addr      = {sel_reg, src_cnt_next[PTR_BITS-1:0]};
                    wr_ptr_next  = dst_cnt[PTR_BITS-1:0];
                    moved_next   = moved_reg + 1'b1;
                end
                pend_next = issue;
                if (!issue && !pend_reg)
                begin
                    state_next = S_EMIT;
                end
            end

            // read entries bottom up, fold each into the running min and max
            S_SCAN:
            begin
                if (pend_reg)
                begin
                    if (first_reg)
                    begin
                        large_next = rd_data_reg;
                        small_next = rd_data_reg;
                        first_next = 1'b0;
                    end
                    else
                    begin
                        if (rd_data_reg > large_reg)
                        begin
                            large_next = rd_data_reg;
                        end
                        if (rd_data_reg < small_reg)
                        begin
                            small_next = rd_data_reg;
                        end
                    end
                end
                issue = (idx_reg < src_cnt);
                if (issue)
                begin
                    rd_en    = 1'b1;
                    rd_addr  = {sel_reg, idx_reg[PTR_BITS-1:0]};
                    idx_next = idx_reg + 1'b1;
                end
                pend_next = issue;
                if (!issue && !pend_reg)
                begin
                    state_next = S_EMIT;
                end
            end

            // load the output register once it is free
            S_EMIT:
            begin
                if (out_free)
                begin
                    m_tvalid_next = 1'b1;
                    m_tuser_next  = status_reg;
                    m_tdata_next  = OUT_DATA_BITS'({
                        to_depth(second_cnt_reg),
                        to_depth(first_cnt_reg),
                        to_depth(moved_reg),
                        to_field(small_reg),
                        to_field(large_reg),
                        popped_reg
                    });
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        first_cnt_next  = cur_sel ? dst_cnt_next : src_cnt_next;
        second_cnt_next = cur_sel ? src_cnt_next : dst_cnt_next;
    end

    // state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            first_cnt_reg  <= '0;
            second_cnt_reg <= '0;
            pend_reg       <= 1'b0;
            m_tvalid_reg   <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            first_cnt_reg  <= first_cnt_next;
            second_cnt_reg <= second_cnt_next;
            pend_reg       <= pend_next;
            m_tvalid_reg   <= m_tvalid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        sel_reg     <= sel_next;
        idx_reg     <= idx_next;
        moved_reg   <= moved_next;
        wr_ptr_reg  <= wr_ptr_next;
        first_reg   <= first_next;
        status_reg  <= status_next;
        popped_reg  <= popped_next;
        large_reg   <= large_next;
        small_reg   <= small_next;
        m_tdata_reg <= m_tdata_next;
        m_tuser_reg <= m_tuser_next;
    end

    // stack memory, one write and one registered read a cycle
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule

// ----- dv/testbench.sv -----
// testbench for the dual stack block: scoreboard against a behavioral stack pair
`timescale 1ns / 1ps

module testbench;

    import dstm_pkg::*;

    // opcodes the block must ignore
    localparam logic [OP_BITS-1:0] OP_UNUSED_LO = 3'd5;
    localparam logic [OP_BITS-1:0] OP_UNUSED_HI = 3'd7;

    // stack select values
    localparam logic FIRST_STACK  = 1'b0;
    localparam logic SECOND_STACK = 1'b1;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 40;
    localparam int HOLD_OFF_LEN   = 300;

    // one result beat, msb first so the low part lines up with m_tdata
    typedef struct packed {
        logic [STATUS_BITS-1:0] status;
        logic [DEPTH_BITS-1:0]  depth1;
        logic [DEPTH_BITS-1:0]  depth0;
        logic [DEPTH_BITS-1:0]  moved;
        logic [VAL_BITS-1:0]    smallest;
        logic [VAL_BITS-1:0]    largest;
        logic [VAL_BITS-1:0]    popped;
    } stack_result_t;

    logic                     clk = 1'b0;
    logic                     rst_n;
    logic                     s_tvalid;
    logic                     s_tready;
    // value[31:0]
    logic [IN_DATA_BITS-1:0]  s_tdata;
    // operation[2:0], stack_select[3]
    logic [IN_USER_BITS-1:0]  s_tuser;
    logic                     m_tvalid;
    logic                     m_tready;
    // popped_value, largest, smallest, moved_count, first_depth, second_depth
    logic [OUT_DATA_BITS-1:0] m_tdata;
    // status[1:0]
    logic [OUT_USER_BITS-1:0] m_tuser;

    // behavioral copy of both stacks
    word_t stack_mem [2][STACK_DEPTH];
    int    stack_fill [2];

    stack_result_t pending_results[$];
    int            fail_count = 0;
    int            idle_cycles = 0;

    // sender and receiver pacing knobs
    int burst_left = 1;
    int gap_max = 0;
    int rx_stall_pct = 0;
    int rx_hold_cycles = 0;

    dual_stack_transfer_minmax uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always #5 clk = ~clk;

    // apply one operation to the stack pair and return the result it yields
    function automatic stack_result_t apply_stack_op(input logic [OP_BITS-1:0] op,
                                                     input logic sel,
                                                     input logic [VAL_BITS-1:0] value);
        stack_result_t r;
        int src;
        int dst;
        int k;
        word_t hi;
        word_t lo;
        r = '0;
        src = sel ? 1 : 0;
        dst = sel ? 0 : 1;
        case (op)
            OP_PUSH:
            begin
                if (stack_fill[src] >= STACK_DEPTH)
                begin
                    r.status = ST_OVERFLOW;
                end
                else
                begin
                    stack_mem[src][stack_fill[src]] = word_t'($signed(value));
                    stack_fill[src]++;
                end
            end
            OP_POP:
            begin
                if (stack_fill[src] == 0)
                begin
                    r.status = ST_UNDERFLOW;
                end
                else
                begin
                    stack_fill[src]--;
                    r.popped = stack_mem[src][stack_fill[src]];
                end
            end
            OP_XFER:
            begin
                // one word at a time, so the moved words end up reversed
                while (stack_fill[src] > 0 && stack_fill[dst] < STACK_DEPTH)
                begin
                    stack_fill[src]--;
                    stack_mem[dst][stack_fill[dst]] = stack_mem[src][stack_fill[src]];
                    stack_fill[dst]++;
                    r.moved++;
                end
            end
            OP_QUERY:
            begin
                if (stack_fill[src] == 0)
                begin
                    r.status = ST_EMPTY;
                end
                else
                begin
                    hi = stack_mem[src][0];
                    lo = stack_mem[src][0];
                    for (k = 1; k < stack_fill[src]; k++)
                    begin
                        if (stack_mem[src][k] > hi)
                            hi = stack_mem[src][k];
                        if (stack_mem[src][k] < lo)
                            lo = stack_mem[src][k];
                    end
                    r.largest  = hi;
                    r.smallest = lo;
                end
            end
            OP_CLEAR:
            begin
                stack_fill[src] = 0;
            end
            default:
            begin
            end
        endcase
        r.depth0 = DEPTH_BITS'(stack_fill[0]);
        r.depth1 = DEPTH_BITS'(stack_fill[1]);
        return r;
    endfunction

    // random word, leaning on the signed extremes now and then
    function automatic logic [VAL_BITS-1:0] pick_word();
        case ($urandom_range(9))
            0: return 32'h7fff_ffff;
            1: return 32'h8000_0000;
            2: return 32'h0000_0000;
            3: return 32'hffff_ffff;
            4: return VAL_BITS'($signed($urandom_range(16)) - 8);
            default: return $urandom;
        endcase
    endfunction

    // offer one beat, record its expected result once accepted, then maybe pause
    task automatic send_stack_op(input logic [OP_BITS-1:0] op, input logic sel,
                                 input logic [VAL_BITS-1:0] value);
        int gap;
        s_tdata  <= value;
        s_tuser  <= {sel, op};
        s_tvalid <= 1'b1;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        pending_results.push_back(apply_stack_op(op, sel, value));
        burst_left--;
        if (burst_left <= 0)
        begin
            burst_left = $urandom_range(24, 1);
            gap = (gap_max == 0) ? 0 : $urandom_range(gap_max);
            if (gap > 0)
            begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    endtask

    // compare one field of a result beat
    task automatic report_field(input string name, input logic [VAL_BITS-1:0] want,
                                input logic [VAL_BITS-1:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0h, actual %0h", name, want, got);
            fail_count++;
        end
    endtask

    // corners: empty stacks, word extremes, every operation on both stacks, unused opcodes on the second
    task automatic test_directed_corners();
        int c;
        gap_max = 2;
        rx_stall_pct = 20;
        send_stack_op(OP_QUERY, FIRST_STACK, 32'h0);
        send_stack_op(OP_QUERY, SECOND_STACK, 32'hffff_ffff);
        send_stack_op(OP_POP, FIRST_STACK, 32'h0);
        send_stack_op(OP_POP, SECOND_STACK, 32'h0);
        send_stack_op(OP_XFER, FIRST_STACK, 32'h0);
        send_stack_op(OP_PUSH, FIRST_STACK, 32'h7fff_ffff);
        send_stack_op(OP_PUSH, FIRST_STACK, 32'h8000_0000);
        send_stack_op(OP_PUSH, FIRST_STACK, 32'h0000_0000);
        send_stack_op(OP_PUSH, FIRST_STACK, 32'hffff_ffff);
        send_stack_op(OP_PUSH, SECOND_STACK, 32'h0000_0001);
        send_stack_op(OP_QUERY, FIRST_STACK, 32'h0);
        send_stack_op(OP_XFER, SECOND_STACK, 32'h0);
        send_stack_op(OP_POP, FIRST_STACK, 32'h0);
        send_stack_op(OP_POP, FIRST_STACK, 32'h0);
        // ignored opcodes must leave both stacks alone
        for (c = OP_UNUSED_LO; c <= OP_UNUSED_HI; c++)
            send_stack_op(OP_BITS'(c), SECOND_STACK, 32'hffff_ffff);
        send_stack_op(OP_CLEAR, FIRST_STACK, 32'h0);
        send_stack_op(OP_QUERY, FIRST_STACK, 32'h0);
        send_stack_op(OP_PUSH, SECOND_STACK, 32'ha5a5_a5a5);
        send_stack_op(OP_CLEAR, SECOND_STACK, 32'h0);
        send_stack_op(OP_QUERY, SECOND_STACK, 32'h0);
    endtask

    // full stacks: overflow, transfers cut short by a full destination
    task automatic test_full_stacks();
        int k;
        gap_max = 3;
        rx_stall_pct = 30;
        send_stack_op(OP_CLEAR, FIRST_STACK, pick_word());
        send_stack_op(OP_CLEAR, SECOND_STACK, pick_word());
        repeat (5) send_stack_op(OP_PUSH, SECOND_STACK, pick_word());
        repeat (STACK_DEPTH + 1) send_stack_op(OP_PUSH, FIRST_STACK, pick_word());
        send_stack_op(OP_QUERY, FIRST_STACK, pick_word());
        send_stack_op(OP_XFER, FIRST_STACK, pick_word());
        send_stack_op(OP_PUSH, SECOND_STACK, pick_word());
        send_stack_op(OP_XFER, SECOND_STACK, pick_word());
        send_stack_op(OP_QUERY, FIRST_STACK, pick_word());
        send_stack_op(OP_QUERY, SECOND_STACK, pick_word());
        for (k = 0; k < 6; k++)
            send_stack_op(OP_POP, SECOND_STACK, pick_word());
        send_stack_op(OP_XFER, FIRST_STACK, pick_word());
        send_stack_op(OP_CLEAR, SECOND_STACK, pick_word());
        send_stack_op(OP_QUERY, SECOND_STACK, pick_word());
    endtask

    // random op mix; push_pct steers stacks toward full or empty
    task automatic test_random_traffic(input int n_items, input int push_pct,
                                       input int gap_lim, input int stall_pct);
        int i;
        int roll;
        logic [OP_BITS-1:0] op;
        gap_max = gap_lim;
        rx_stall_pct = stall_pct;
        for (i = 0; i < n_items; i++)
        begin
            if ($urandom_range(99) < push_pct)
            begin
                op = OP_PUSH;
            end
            else
            begin
                roll = $urandom_range(99);
                if (roll < 45)
                    op = OP_POP;
                else if (roll < 68)
                    op = OP_QUERY;
                else if (roll < 88)
                    op = OP_XFER;
                else if (roll < 93)
                    op = OP_CLEAR;
                else
                    op = OP_BITS'($urandom_range(OP_UNUSED_HI, OP_UNUSED_LO));
            end
            send_stack_op(op, 1'($urandom_range(1)), pick_word());
        end
    endtask

    // receiver holds off for a long stretch while the sender keeps offering
    task automatic test_output_backpressure();
        rx_hold_cycles = HOLD_OFF_LEN;
        test_random_traffic(40, 50, 0, 0);
    endtask

    // receiver: random stalls, or a long hold-off when one is requested
    initial
    begin
        m_tready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (rx_hold_cycles > 0)
            begin
                m_tready <= 1'b0;
                repeat (rx_hold_cycles) @(posedge clk);
                rx_hold_cycles = 0;
            end
            else
            begin
                m_tready <= ($urandom_range(99) >= rx_stall_pct);
            end
        end
    end

    // result checker: each accepted beat against the oldest expectation
    always @(posedge clk)
    begin : check_results
        stack_result_t want;
        stack_result_t got;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_results.size() == 0)
            begin
                $error("result beat with no operation pending");
                fail_count++;
            end
            else
            begin
                want = pending_results.pop_front();
                got  = {m_tuser, m_tdata[OUT_RAW_BITS-1:0]};
                report_field("status", VAL_BITS'(want.status), VAL_BITS'(got.status));
                report_field("popped_value", want.popped, got.popped);
                report_field("largest", want.largest, got.largest);
                report_field("smallest", want.smallest, got.smallest);
                report_field("moved_count", VAL_BITS'(want.moved), VAL_BITS'(got.moved));
                report_field("first_depth", VAL_BITS'(want.depth0), VAL_BITS'(got.depth0));
                report_field("second_depth", VAL_BITS'(want.depth1), VAL_BITS'(got.depth1));
            end
        end
    end

    // watchdog on cycles without any accepted beat
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // test sequence
    initial
    begin
        rst_n    = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tuser  = '0;
        stack_fill[0] = 0;
        stack_fill[1] = 0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_corners();
        test_full_stacks();
        test_random_traffic(400, 65, 6, 25);
        test_random_traffic(300, 25, 3, 40);
        test_random_traffic(300, 45, 0, 0);
        test_output_backpressure();
        test_random_traffic(550, 50, 10, 60);

        s_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

// ----- sim.f -----
hdl/dstm_pkg.sv
hdl/dual_stack_transfer_minmax.sv
dv/testbench.sv
